// ===== hw/rtl/fba_pkg.sv =====
package fba_pkg;

  localparam int WORD_BITS       = 32;
  localparam int BIT_W           = 5;
  localparam int ADDR_W          = 32;
  localparam int RSV_W           = 13;
  localparam int FRAME_TOTAL_DEF = 4096;
  localparam int PAGE_SHIFT_DEF  = 12;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] phys_addr;
  } cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0] frame_addr;
    status_t           status;
    logic              is_free;
  } result_t;

  typedef enum logic [1:0] {
    WOP_ALLOC,
    WOP_CLEAR,
    WOP_FILL
  } word_op_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] new_word;
    logic                 zero_found;
    logic [BIT_W-1:0]     zero_pos;
    logic                 bit_used;
  } word_res_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_INIT,
    S_INIT_WR,
    S_ALLOC_CHK,
    S_ADDR
  } state_t;

endpackage

// ===== hw/rtl/fba_map_ram.sv =====
module fba_map_ram #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic [fba_pkg::WORD_BITS-1:0] wdata,
  input  logic                          re,
  input  logic [AW-1:0]                 raddr,
  output logic [fba_pkg::WORD_BITS-1:0] rdata
);
  import fba_pkg::*;

  logic [WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/fba_word_unit.sv =====
module fba_word_unit (
  input  fba_pkg::word_op_t                 wop,
  input  logic [fba_pkg::WORD_BITS-1:0]     word,
  input  logic [fba_pkg::BIT_W-1:0]         bit_sel,
  input  logic [fba_pkg::BIT_W-1:0]         fill_cnt,
  output fba_pkg::word_res_t                res
);
  import fba_pkg::*;

  logic [WORD_BITS-1:0] lowest_zero;
  logic [WORD_BITS-1:0] sel_mask;
  logic [WORD_BITS-1:0] fill_mask;
  logic [BIT_W-1:0]     pos;

  // isolate the lowest clear bit
  assign lowest_zero = ~word & (word + WORD_BITS'(1));
  assign sel_mask    = WORD_BITS'(1) << bit_sel;
  assign fill_mask   = (WORD_BITS'(1) << fill_cnt) - WORD_BITS'(1);

  always_comb begin
    pos = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (lowest_zero[i]) begin
        pos = BIT_W'(i);
      end
    end
  end

  always_comb begin
    res.zero_found = ~&word;
    res.zero_pos   = pos;
    res.bit_used   = word[bit_sel];
    case (wop)
      WOP_ALLOC: res.new_word = word | lowest_zero;
      WOP_CLEAR: res.new_word = word & ~sel_mask;
      WOP_FILL:  res.new_word = word | fill_mask;
      default:   res.new_word = word;
    endcase
  end

endmodule

// ===== hw/rtl/frame_bitmap_allocator_core.sv =====
// Page-frame allocator: one bit per frame in an internal bitmap RAM, set = used.
// Command channel: cmd (op, phys_addr) is taken at a clock edge with start high
// and busy low. busy is high only while the bitmap is being worked on and is low
// again in the result cycle. Ops: init marks frames below reserved_frames used, alloc
// takes the lowest free frame, free clears a frame, query reports whether it is free.
// Result channel: result_valid is high for exactly one cycle with result; the
// receiver cannot stall it, so it must take every result as it comes.
// Config channel: cfg_data (reserved_frames) is written when cfg_valid and
// cfg_ready are high; cfg_ready is always high. Write it only while idle.
// Work done between the accepting edge and the result:
//   free, query: one bitmap read, then a write or compare;
//   out-of-range free/query and alloc on a known-full map: no bitmap access;
//   alloc: scanned words are read in turn, starting from the lowest word that
//   may hold a free frame, and the word with a free frame is written back;
//   init: writes each fully reserved word, then read-merges a partial last word.
// The next command can be taken at the edge that ends its predecessor's result cycle.
// After reset the bitmap is cleared one word per cycle, from word 0 to the last,
// with busy high; config writes are taken throughout.
module frame_bitmap_allocator_core #(
  parameter int FRAME_TOTAL = fba_pkg::FRAME_TOTAL_DEF,
  parameter int PAGE_SHIFT  = fba_pkg::PAGE_SHIFT_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  fba_pkg::cmd_t             cmd,
  output logic                      result_valid,
  output fba_pkg::result_t          result,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [fba_pkg::RSV_W-1:0] cfg_data
);
  import fba_pkg::*;

  localparam int MAP_WORDS = (FRAME_TOTAL + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int HINT_W    = $clog2(MAP_WORDS + 1);
  localparam int CNT_W     = $clog2(FRAME_TOTAL + 1);
  localparam int TAIL      = FRAME_TOTAL % WORD_BITS;
  localparam logic [WORD_BITS-1:0] TAIL_MASK =
    (TAIL == 0) ? '0 : ~((WORD_BITS'(1) << TAIL) - WORD_BITS'(1));

  state_t             state, state_next;
  logic [HINT_W-1:0]  ptr, ptr_next;
  logic [HINT_W-1:0]  hint, hint_next;
  logic [CNT_W-1:0]   remaining, remaining_next;
  logic [WIDX_W-1:0]  aw, aw_next;
  logic [BIT_W-1:0]   ab, ab_next;
  op_t                op_q, op_next;
  logic [RSV_W-1:0]   reserved_frames;
  logic               result_valid_next;
  result_t            result_next;

  logic                 mem_we;
  logic [WIDX_W-1:0]    mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [WIDX_W-1:0]    mem_raddr;
  logic [WORD_BITS-1:0] mem_rdata;

  word_op_t             wop;
  logic [WORD_BITS-1:0] unit_word;
  word_res_t            unit_res;

  logic [ADDR_W-1:0]    cmd_idx;
  logic                 cmd_in_range;
  logic                 ptr_last;
  logic [63:0]          alloc_addr;

  fba_map_ram #(
    .DEPTH (MAP_WORDS),
    .AW    (WIDX_W)
  ) u_map_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  fba_word_unit u_word_unit (
    .wop      (wop),
    .word     (unit_word),
    .bit_sel  (ab),
    .fill_cnt (remaining[BIT_W-1:0]),
    .res      (unit_res)
  );

  assign cfg_ready    = 1'b1;
  assign busy         = (state != S_IDLE);
  assign cmd_idx      = cmd.phys_addr >> PAGE_SHIFT;
  assign cmd_in_range = (cmd_idx < ADDR_W'(FRAME_TOTAL));
  assign ptr_last     = (ptr == HINT_W'(MAP_WORDS - 1));
  assign alloc_addr   = 64'({ptr[WIDX_W-1:0], unit_res.zero_pos}) << PAGE_SHIFT;

  always_comb begin
    case (state)
      S_ALLOC_CHK: begin
        wop       = WOP_ALLOC;
        unit_word = mem_rdata | (ptr_last ? TAIL_MASK : '0);
      end
      S_INIT_WR: begin
        wop       = WOP_FILL;
        unit_word = mem_rdata;
      end
      default: begin
        wop       = WOP_CLEAR;
        unit_word = mem_rdata;
      end
    endcase
  end

  always_comb begin
    state_next        = state;
    ptr_next          = ptr;
    hint_next         = hint;
    remaining_next    = remaining;
    aw_next           = aw;
    ab_next           = ab;
    op_next           = op_q;
    result_valid_next = 1'b0;
    result_next       = '0;
    mem_we            = 1'b0;
    mem_waddr         = ptr[WIDX_W-1:0];
    mem_wdata         = '0;
    mem_re            = 1'b0;
    mem_raddr         = ptr[WIDX_W-1:0];

    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (ptr_last) begin
          ptr_next   = '0;
          state_next = S_IDLE;
        end else begin
          ptr_next = ptr + HINT_W'(1);
        end
      end

      S_IDLE: begin
        if (start) begin
          op_next = cmd.op;
          aw_next = cmd_idx[BIT_W +: WIDX_W];
          ab_next = cmd_idx[BIT_W-1:0];
          case (cmd.op)
            OP_INIT: begin
              ptr_next = '0;
              if (32'(reserved_frames) > 32'(FRAME_TOTAL)) begin
                remaining_next = CNT_W'(FRAME_TOTAL);
              end else begin
                remaining_next = CNT_W'(reserved_frames);
              end
              state_next = S_INIT;
            end
            OP_ALLOC: begin
              if (hint == HINT_W'(MAP_WORDS)) begin
                result_valid_next  = 1'b1;
                result_next.status = ST_FULL;
              end else begin
                ptr_next   = hint;
                mem_re     = 1'b1;
                mem_raddr  = hint[WIDX_W-1:0];
                state_next = S_ALLOC_CHK;
              end
            end
            default: begin
              if (cmd_in_range) begin
                mem_re     = 1'b1;
                mem_raddr  = cmd_idx[BIT_W +: WIDX_W];
                state_next = S_ADDR;
              end else begin
                result_valid_next  = 1'b1;
                result_next.status = ST_RANGE;
              end
            end
          endcase
        end
      end

      S_INIT: begin
        if (32'(remaining) >= 32'(WORD_BITS)) begin
          mem_we         = 1'b1;
          mem_wdata      = '1;
          remaining_next = remaining - CNT_W'(WORD_BITS);
          ptr_next       = ptr + HINT_W'(1);
        end else if (remaining != '0) begin
          // partial last word: merge into what is already there
          mem_re     = 1'b1;
          state_next = S_INIT_WR;
        end else begin
          result_valid_next = 1'b1;
          state_next        = S_IDLE;
        end
      end

      S_INIT_WR: begin
        mem_we            = 1'b1;
        mem_wdata         = unit_res.new_word;
        remaining_next    = '0;
        result_valid_next = 1'b1;
        state_next        = S_IDLE;
      end

      S_ALLOC_CHK: begin
        if (unit_res.zero_found) begin
          mem_we                 = 1'b1;
          mem_wdata              = unit_res.new_word;
          hint_next              = ptr;
          result_valid_next      = 1'b1;
          result_next.frame_addr = alloc_addr[ADDR_W-1:0];
          state_next             = S_IDLE;
        end else if (ptr_last) begin
          hint_next          = HINT_W'(MAP_WORDS);
          result_valid_next  = 1'b1;
          result_next.status = ST_FULL;
          state_next         = S_IDLE;
        end else begin
          // advance to the next word, read issued now for next cycle
          ptr_next  = ptr + HINT_W'(1);
          mem_re    = 1'b1;
          mem_raddr = WIDX_W'(ptr + HINT_W'(1));
        end
      end

      S_ADDR: begin
        result_valid_next = 1'b1;
        state_next        = S_IDLE;
        if (op_q == OP_FREE) begin
          mem_we    = 1'b1;
          mem_waddr = aw;
          mem_wdata = unit_res.new_word;
          if (HINT_W'(aw) < hint) begin
            hint_next = HINT_W'(aw);
          end
        end else begin
          result_next.is_free = ~unit_res.bit_used;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLEAR;
      ptr             <= '0;
      hint            <= '0;
      reserved_frames <= '0;
      result_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      ptr          <= ptr_next;
      hint         <= hint_next;
      result_valid <= result_valid_next;
      if (cfg_valid && cfg_ready) begin
        reserved_frames <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    remaining <= remaining_next;
    aw        <= aw_next;
    ab        <= ab_next;
    op_q      <= op_next;
    result    <= result_next;
  end

endmodule
